// ----- design/bsmh_pkg.sv -----
`timescale 1ns / 1ps

package bsmh_pkg;

  localparam logic [31:0] GOLDEN    = 32'h9e3779b9;
  localparam logic [3:0]  BLOCK_LEN = 4'd12;
  localparam int          MIX_ROWS  = 9;
  localparam int          ROW_W     = 4;
  localparam int          OUT_DEPTH = 16;
  localparam int          OUT_AW    = $clog2(OUT_DEPTH);
  localparam int          CNT_W     = OUT_AW + 1;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mix_words_t;

  typedef struct packed {
    logic       valid;
    logic       fin;
    mix_words_t w;
  } mix_slot_t;

  // one line of the reversible mix
  function automatic mix_words_t mix_row(mix_words_t m, logic [ROW_W-1:0] row);
    mix_words_t r;
    r = m;
    case (row)
      4'd0: r.a = (m.a - m.b - m.c) ^ (m.c >> 13);
      4'd1: r.b = (m.b - m.c - m.a) ^ (m.a << 8);
      4'd2: r.c = (m.c - m.a - m.b) ^ (m.b >> 13);
      4'd3: r.a = (m.a - m.b - m.c) ^ (m.c >> 12);
      4'd4: r.b = (m.b - m.c - m.a) ^ (m.a << 16);
      4'd5: r.c = (m.c - m.a - m.b) ^ (m.b >> 5);
      4'd6: r.a = (m.a - m.b - m.c) ^ (m.c >> 3);
      4'd7: r.b = (m.b - m.c - m.a) ^ (m.a << 10);
      4'd8: r.c = (m.c - m.a - m.b) ^ (m.b >> 15);
      default: r = m;
    endcase
    return r;
  endfunction

endpackage

// ----- design/bsmh_in_if.sv -----
`timescale 1ns / 1ps

interface bsmh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first;
  logic [31:0] seed;
  logic        last;
  logic        empty_req;

  modport source (output valid, data_byte, first, seed, last, empty_req, input ready);
  modport sink   (input valid, data_byte, first, seed, last, empty_req, output ready);
endinterface

// ----- design/bsmh_out_if.sv -----
`timescale 1ns / 1ps

interface bsmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ----- design/bsmh_mix_pipe.sv -----
`timescale 1ns / 1ps

module bsmh_mix_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  bsmh_pkg::mix_slot_t launch,
  output bsmh_pkg::mix_slot_t done
);

  logic [bsmh_pkg::MIX_ROWS:0] vld_r;
  logic [bsmh_pkg::MIX_ROWS:0] fin_r;
  bsmh_pkg::mix_words_t        w_r [0:bsmh_pkg::MIX_ROWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[bsmh_pkg::MIX_ROWS-1:0], launch.valid};
    end
  end

  always_ff @(posedge clk) begin
    fin_r  <= {fin_r[bsmh_pkg::MIX_ROWS-1:0], launch.fin};
    w_r[0] <= launch.w;
    for (int k = 1; k <= bsmh_pkg::MIX_ROWS; k++) begin
      w_r[k] <= bsmh_pkg::mix_row(w_r[k-1], bsmh_pkg::ROW_W'(k - 1));
    end
  end

  assign done.valid = vld_r[bsmh_pkg::MIX_ROWS];
  assign done.fin   = fin_r[bsmh_pkg::MIX_ROWS];
  assign done.w     = w_r[bsmh_pkg::MIX_ROWS];

endmodule

// ----- design/bsmh_gather.sv -----
`timescale 1ns / 1ps

module bsmh_gather (
  input  logic                clk,
  input  logic                rst_n,
  bsmh_in_if.sink             in_if,
  input  logic                out_xfer,
  input  bsmh_pkg::mix_slot_t done,
  output bsmh_pkg::mix_slot_t launch
);

  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [95:0] blk_r, blk_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic        mix_busy_r, mix_busy_nxt;
  logic        fin_pend_r, fin_pend_nxt;
  logic [31:0] ta_r, ta_nxt, tb_r, tb_nxt, tc_r, tc_nxt;
  logic [bsmh_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic        acc, restart, wb, full;
  logic [31:0] a_base, b_base, c_base, len_base;
  logic [95:0] blk_base, blk_new;
  logic [3:0]  pos_base, pos_inc;
  logic [31:0] ta, tb, tc;

  assign in_if.ready = !fin_pend_r && (cnt_r != bsmh_pkg::CNT_W'(bsmh_pkg::OUT_DEPTH));
  assign acc         = in_if.valid && in_if.ready;
  assign restart     = acc && in_if.first;
  assign wb          = done.valid && !done.fin && mix_busy_r;

  always_comb begin
    a_base   = restart ? bsmh_pkg::GOLDEN : a_r;
    b_base   = restart ? bsmh_pkg::GOLDEN : b_r;
    c_base   = restart ? in_if.seed : c_r;
    blk_base = restart ? '0 : blk_r;
    pos_base = restart ? '0 : pos_r;
    len_base = restart ? '0 : len_r;

    blk_new = blk_base;
    pos_inc = pos_base + 4'd1;
    full    = !in_if.empty_req && (pos_inc == bsmh_pkg::BLOCK_LEN);

    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    blk_nxt      = blk_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    mix_busy_nxt = mix_busy_r;
    fin_pend_nxt = fin_pend_r;
    ta_nxt       = ta_r;
    tb_nxt       = tb_r;
    tc_nxt       = tc_r;
    launch       = '0;
    ta           = '0;
    tb           = '0;
    tc           = '0;

    if (wb) begin
      a_nxt        = done.w.a;
      b_nxt        = done.w.b;
      c_nxt        = done.w.c;
      mix_busy_nxt = 1'b0;
    end

    if (fin_pend_r && !mix_busy_r) begin
      launch.valid = 1'b1;
      launch.fin   = 1'b1;
      launch.w.a   = a_r + ta_r;
      launch.w.b   = b_r + tb_r;
      launch.w.c   = c_r + tc_r;
      fin_pend_nxt = 1'b0;
      a_nxt        = bsmh_pkg::GOLDEN;
      b_nxt        = bsmh_pkg::GOLDEN;
      c_nxt        = '0;
      blk_nxt      = '0;
      pos_nxt      = '0;
      len_nxt      = '0;
    end

    if (acc) begin
      if (restart) begin
        a_nxt        = a_base;
        b_nxt        = b_base;
        c_nxt        = c_base;
        mix_busy_nxt = 1'b0;
      end
      blk_nxt = blk_base;
      pos_nxt = pos_base;
      len_nxt = len_base;
      if (!in_if.empty_req) begin
        blk_new[{pos_base, 3'b000} +: 8] = in_if.data_byte;
        len_nxt = len_base + 32'd1;
        if (full) begin
          launch.valid = 1'b1;
          launch.fin   = 1'b0;
          launch.w.a   = a_base + blk_new[31:0];
          launch.w.b   = b_base + blk_new[63:32];
          launch.w.c   = c_base + blk_new[95:64];
          mix_busy_nxt = 1'b1;
          blk_nxt      = '0;
          pos_nxt      = '0;
        end else begin
          blk_nxt = blk_new;
          pos_nxt = pos_inc;
        end
      end

      ta = blk_nxt[31:0];
      tb = blk_nxt[63:32];
      tc = len_nxt + {blk_nxt[87:64], 8'h00};

      if (in_if.last) begin
        if (full || (mix_busy_r && !restart)) begin
          fin_pend_nxt = 1'b1;
          ta_nxt       = ta;
          tb_nxt       = tb;
          tc_nxt       = tc;
        end else begin
          launch.valid = 1'b1;
          launch.fin   = 1'b1;
          launch.w.a   = a_base + ta;
          launch.w.b   = b_base + tb;
          launch.w.c   = c_base + tc;
          a_nxt        = bsmh_pkg::GOLDEN;
          b_nxt        = bsmh_pkg::GOLDEN;
          c_nxt        = '0;
          blk_nxt      = '0;
          pos_nxt      = '0;
          len_nxt      = '0;
          mix_busy_nxt = 1'b0;
        end
      end
    end

    cnt_nxt = cnt_r + bsmh_pkg::CNT_W'(acc && in_if.last) - bsmh_pkg::CNT_W'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r        <= bsmh_pkg::GOLDEN;
      b_r        <= bsmh_pkg::GOLDEN;
      c_r        <= '0;
      blk_r      <= '0;
      pos_r      <= '0;
      len_r      <= '0;
      mix_busy_r <= 1'b0;
      fin_pend_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      c_r        <= c_nxt;
      blk_r      <= blk_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      mix_busy_r <= mix_busy_nxt;
      fin_pend_r <= fin_pend_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ta_r <= ta_nxt;
    tb_r <= tb_nxt;
    tc_r <= tc_nxt;
  end

  // a new block never enters the mixer while the previous one is still in it
  a_blk_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    !(launch.valid && !launch.fin && mix_busy_r))
    else $error("block mix launched while previous block mix in flight");

  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_pend_r |-> !in_if.ready)
    else $error("input taken while finish pending");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= bsmh_pkg::CNT_W'(bsmh_pkg::OUT_DEPTH))
    else $error("outstanding hash count overflow");

endmodule

// ----- design/bsmh_out_fifo.sv -----
`timescale 1ns / 1ps

module bsmh_out_fifo (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [31:0] wr_data,
  bsmh_out_if.source  out_if
);

  logic [31:0]                 mem_r [0:bsmh_pkg::OUT_DEPTH-1];
  logic [bsmh_pkg::OUT_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [bsmh_pkg::CNT_W-1:0]  cnt_r;
  logic                        out_vld_r;
  logic [31:0]                 out_dat_r;
  logic                        rd_en, take, from_mem, bypass, push_mem;

  assign out_if.valid      = out_vld_r;
  assign out_if.hash_value = out_dat_r;
  assign rd_en             = out_vld_r && out_if.ready;
  assign take              = !out_vld_r || rd_en;
  assign from_mem          = take && (cnt_r != '0);
  // head register free (empty or being read) and queue empty: new hash goes straight to the head
  assign bypass            = take && (cnt_r == '0) && wr_en;
  assign push_mem          = wr_en && !bypass;

  always_ff @(posedge clk) begin
    if (push_mem) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
    if (from_mem) begin
      out_dat_r <= mem_r[rd_ptr_r];
    end else if (bypass) begin
      out_dat_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_r + bsmh_pkg::OUT_AW'(push_mem);
      rd_ptr_r <= rd_ptr_r + bsmh_pkg::OUT_AW'(from_mem);
      cnt_r    <= cnt_r + bsmh_pkg::CNT_W'(push_mem) - bsmh_pkg::CNT_W'(from_mem);
      if (from_mem || bypass) begin
        out_vld_r <= 1'b1;
      end else if (rd_en) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_mem && !from_mem && (cnt_r == bsmh_pkg::CNT_W'(bsmh_pkg::OUT_DEPTH))))
    else $error("hash queue overrun");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_if.ready) |=> (out_vld_r && $stable(out_dat_r)))
    else $error("hash transfer dropped or changed while stalled");

endmodule

// ----- design/byte_stream_mix_hash_32.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    data_byte[7:0], first, seed[31:0], last, empty_req
// out_if    out  valid/ready    hash_value[31:0]
//
// One key byte per cycle while in_if.ready is high; full 12-byte blocks go through a 9-stage mix pipeline.
// Hash shows on out_if once the final mix has passed the mix pipeline, and later when the last
// byte closes a block or follows a block boundary while that block mix is still in flight
// (in_if.ready is low while that block mix drains).
// Up to 16 hashes may be queued or in flight; in_if.ready drops at that limit.
// rst_n is synchronous, active low, and clears the key and queue control state (data registers are not reset).

module byte_stream_mix_hash_32 (
  input  logic       clk,
  input  logic       rst_n,
  bsmh_in_if.sink    in_if,
  bsmh_out_if.source out_if
);

  bsmh_pkg::mix_slot_t launch;
  bsmh_pkg::mix_slot_t done;
  logic                out_xfer;

  assign out_xfer = out_if.valid && out_if.ready;

  bsmh_gather u_gather (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_xfer (out_xfer),
    .done     (done),
    .launch   (launch)
  );

  bsmh_mix_pipe u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .launch (launch),
    .done   (done)
  );

  bsmh_out_fifo u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (done.valid && done.fin),
    .wr_data (done.w.c),
    .out_if  (out_if)
  );

endmodule
